>>> hw/rtl/cfb_pkg.sv
// Shared types, constants and the CRC-8 byte update for the command frame builder.
// No dependencies; every other file of the block but cfb_checker imports this package.
package cfb_pkg;

    // Frame limits and result batch sizing
    localparam int unsigned MAX_PAYLOAD = 64;
    localparam int unsigned NUM_RES     = 5;
    localparam int unsigned CNT_W       = $clog2(NUM_RES + 1);

    // CRC-8: polynomial 0x07, MSB first, initial value zero
    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] CRC_INIT     = 8'h00;
    localparam logic [7:0] VERSION_RST  = 8'h01;
    localparam logic [7:0] SEQ_RST      = 8'h01;

    // Item kind codes
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] command;
        logic [7:0] length;
        logic [7:0] payload_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       error;
    } result_t;

    typedef struct packed {
        result_t [NUM_RES-1:0] res;
        logic    [CNT_W-1:0]   count;
    } batch_t;

    // Fold one byte into the running CRC
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/cfb_in_reg.sv
// Input register of the command frame builder: holds one accepted item.
// Depends on cfb_pkg for the item type.
module cfb_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  cfb_pkg::item_t in_item,
    input  logic           take,
    output logic           ir_valid,
    output cfb_pkg::item_t ir_item
);
    import cfb_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic  accept;

    // Stall only while a held item cannot move on
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
    end

    assign ir_valid = valid_reg;
    assign ir_item  = item_reg;

endmodule

>>> hw/rtl/cfb_frame_core.sv
// Frame state and result generation: header, payload, CRC trailer and error results.
// Depends on cfb_pkg for types, limits and the CRC-8 byte function.
module cfb_frame_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data,
    input  cfb_pkg::item_t  item,
    input  logic            take,
    output cfb_pkg::batch_t batch
);
    import cfb_pkg::*;

    logic       in_frame_reg,   in_frame_next;
    logic [6:0] bytes_left_reg, bytes_left_next;
    logic [7:0] crc_acc_reg,    crc_acc_next;
    logic [7:0] seq_reg,        seq_next;
    logic [7:0] version_reg;

    logic [7:0] hdr_crc;
    logic [7:0] pay_crc;
    logic [6:0] left_dec;
    logic       too_long;

    // Header and payload CRC terms
    assign hdr_crc  = crc8_byte(crc8_byte(crc8_byte(crc8_byte(CRC_INIT, version_reg),
                                item.command), seq_reg), item.length);
    assign pay_crc  = crc8_byte(crc_acc_reg, item.payload_byte);
    assign left_dec = bytes_left_reg - 7'd1;
    assign too_long = item.length > 8'(MAX_PAYLOAD);

    // Build the result batch and next state for the held item
    always_comb
    begin
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        crc_acc_next    = crc_acc_reg;
        seq_next        = seq_reg;
        batch           = '0;

        if (item.kind == KIND_HEADER) begin
            if (too_long) begin
                batch.res[0] = '{data: 8'h00, frame_end: 1'b1, error: 1'b1};
                batch.count  = CNT_W'(1);
            end else begin
                seq_next     = seq_reg + 8'd1;
                batch.res[0] = '{data: version_reg,  frame_end: 1'b0, error: 1'b0};
                batch.res[1] = '{data: item.command, frame_end: 1'b0, error: 1'b0};
                batch.res[2] = '{data: seq_reg,      frame_end: 1'b0, error: 1'b0};
                batch.res[3] = '{data: item.length,  frame_end: 1'b0, error: 1'b0};
                if (item.length == 8'd0) begin
                    batch.res[4]    = '{data: hdr_crc, frame_end: 1'b1, error: 1'b0};
                    batch.count     = CNT_W'(5);
                    in_frame_next   = 1'b0;
                    bytes_left_next = 7'd0;
                    crc_acc_next    = CRC_INIT;
                end else begin
                    batch.count     = CNT_W'(4);
                    in_frame_next   = 1'b1;
                    bytes_left_next = item.length[6:0];
                    crc_acc_next    = hdr_crc;
                end
            end
        end else begin
            if (!in_frame_reg || bytes_left_reg == 7'd0) begin
                batch.res[0] = '{data: 8'h00, frame_end: 1'b1, error: 1'b1};
                batch.count  = CNT_W'(1);
            end else begin
                batch.res[0]    = '{data: item.payload_byte, frame_end: 1'b0, error: 1'b0};
                bytes_left_next = left_dec;
                if (left_dec == 7'd0) begin
                    batch.res[1]  = '{data: pay_crc, frame_end: 1'b1, error: 1'b0};
                    batch.count   = CNT_W'(2);
                    in_frame_next = 1'b0;
                    crc_acc_next  = CRC_INIT;
                end else begin
                    batch.count  = CNT_W'(1);
                    crc_acc_next = pay_crc;
                end
            end
        end
    end

    // Advance frame state when the item moves to the output queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 7'd0;
            crc_acc_reg    <= CRC_INIT;
            seq_reg        <= SEQ_RST;
        end else if (take) begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            crc_acc_reg    <= crc_acc_next;
            seq_reg        <= seq_next;
        end
    end

    // Version register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            version_reg <= VERSION_RST;
        else if (cfg_wr_en)
            version_reg <= cfg_wr_data;
    end

endmodule

>>> hw/rtl/cfb_out_queue.sv
// Result register bank: holds one batch of up to five frame bytes and shifts them out.
// Depends on cfb_pkg for the result and batch types.
module cfb_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cfb_pkg::batch_t  batch,
    output logic             space,
    output logic             out_valid,
    input  logic             out_stall,
    output cfb_pkg::result_t out_res
);
    import cfb_pkg::*;

    result_t    entries_reg  [NUM_RES];
    result_t    entries_next [NUM_RES];
    logic [CNT_W-1:0] left_reg;
    logic       out_take;

    assign out_valid = left_reg != '0;
    assign out_take  = out_valid && !out_stall;
    // Free once the last held result leaves this cycle
    assign space     = (left_reg == '0) || (left_reg == CNT_W'(1) && out_take);
    assign out_res   = entries_reg[0];

    // Load a new batch or shift toward the head
    always_comb
    begin
        for (int i = 0; i < NUM_RES; i++) begin
            if (load)
                entries_next[i] = batch.res[i];
            else if (out_take && i < NUM_RES - 1)
                entries_next[i] = entries_reg[i + 1];
            else
                entries_next[i] = entries_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_RES; i++)
            entries_reg[i] <= entries_next[i];
    end

    // Count results still to deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (load)
            left_reg <= batch.count;
        else if (out_take)
            left_reg <= left_reg - CNT_W'(1);
    end

endmodule

>>> hw/rtl/command_frame_builder_crc8_top.sv
// Top level of the command frame builder with CRC-8 trailer.
// Depends on cfb_pkg, cfb_in_reg, cfb_frame_core and cfb_out_queue.
//
// Usage:
//   Input channel (in_valid/in_stall) takes header items (kind 0: command,
//   length) and payload items (kind 1: payload_byte). Output channel
//   (out_valid/out_stall) gives frame bytes, one per result, with frame_end and
//   error flags. A header gives version, command, sequence and length, plus
//   the CRC byte at once if length is zero; a payload item gives its byte,
//   plus the CRC byte after the last one. Bad items give one error result.
//   An item is registered in the input register; its results are then loaded
//   into the output queue once it has space, and shown from its head.
//   Throughput: one item per cycle while each gives a single result and the
//   receiver does not stall; an item with several results holds the input
//   until the output queue has drained them (four or five for a header).
//   cfg_wr_en/cfg_wr_data write the protocol version; write it while idle.
//   Reset: no frame open, sequence 1, version 1, queue empty; ready at once.
//   When the receiver stalls, the current result holds and the input stalls
//   once the held item cannot move into the queue.
module command_frame_builder_crc8_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] command,
    input  logic [7:0] length,
    input  logic [7:0] payload_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       frame_end,
    output logic       error
);
    import cfb_pkg::*;

    item_t   in_item;
    item_t   ir_item;
    logic    ir_valid;
    logic    space;
    logic    take;
    batch_t  batch;
    result_t out_res;

    assign in_item = '{kind: kind, command: command, length: length,
                       payload_byte: payload_byte};
    assign take    = ir_valid && space;

    cfb_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .take     (take),
        .ir_valid (ir_valid),
        .ir_item  (ir_item)
    );

    cfb_frame_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (ir_item),
        .take        (take),
        .batch       (batch)
    );

    cfb_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .batch     (batch),
        .space     (space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign out_byte  = out_res.data;
    assign frame_end = out_res.frame_end;
    assign error     = out_res.error;

endmodule

>>> hw/rtl/cfb_checker.sv
// Port-level checks for the command frame builder, bound to the top level.
// Depends on command_frame_builder_crc8_top for the bind target.
module cfb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       frame_end,
    input logic       error
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(frame_end) && $stable(error))
        else $error("stalled result changed");

    // Close the frame on every error result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> frame_end)
        else $error("error result without frame_end");

    // Send zero on every error result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> out_byte == 8'h00)
        else $error("error result with nonzero byte");

    // Never stall the input while the output queue is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind command_frame_builder_crc8_top cfb_checker u_cfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .frame_end (frame_end),
    .error     (error)
);

>>> verif/tb_command_frame_builder_crc8_top.sv
// Self-checking testbench for command_frame_builder_crc8_top: directed and random frames,
// with a frame tracker that predicts every output byte. Depends on cfb_pkg and the RTL.
module tb_command_frame_builder_crc8_top;

    import cfb_pkg::*;

    // Tracks frame state and holds the bytes the block is due to emit
    class frame_tracker;
        logic [7:0] version;
        logic       open;
        logic [6:0] left;
        logic [7:0] crc_run;
        logic [7:0] seq;
        result_t    due_bytes[$];
        int         failures;

        function new();
            version  = VERSION_RST;
            open     = 1'b0;
            left     = '0;
            crc_run  = CRC_INIT;
            seq      = SEQ_RST;
            failures = 0;
        endfunction

        function void set_version(logic [7:0] v);
            version = v;
        endfunction

        // Shift one byte through the CRC register, bit by bit, MSB first
        function logic [7:0] crc_fold(logic [7:0] acc, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb  = acc[7] ^ b[i];
                acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return acc;
        endfunction

        function void push(logic [7:0] d, logic fe, logic er);
            result_t r;
            r.data      = d;
            r.frame_end = fe;
            r.error     = er;
            due_bytes.push_back(r);
        endfunction

        // Predict the bytes caused by one accepted item
        function void note_item(logic k, logic [7:0] cmd, logic [7:0] len, logic [7:0] pb);
            logic [7:0] s;
            logic [7:0] c;
            if (k == KIND_HEADER) begin
                if (len > MAX_PAYLOAD) begin
                    push(8'h00, 1'b1, 1'b1);
                    return;
                end
                s   = seq;
                seq = seq + 8'd1;
                push(version, 1'b0, 1'b0);
                push(cmd, 1'b0, 1'b0);
                push(s, 1'b0, 1'b0);
                push(len, 1'b0, 1'b0);
                c = crc_fold(CRC_INIT, version);
                c = crc_fold(c, cmd);
                c = crc_fold(c, s);
                c = crc_fold(c, len);
                if (len == 8'd0) begin
                    push(c, 1'b1, 1'b0);
                    open    = 1'b0;
                    left    = '0;
                    crc_run = CRC_INIT;
                end
                else begin
                    open    = 1'b1;
                    left    = len[6:0];
                    crc_run = c;
                end
            end
            else begin
                if (!open || left == '0) begin
                    push(8'h00, 1'b1, 1'b1);
                    return;
                end
                push(pb, 1'b0, 1'b0);
                crc_run = crc_fold(crc_run, pb);
                left    = left - 7'd1;
                if (left == '0) begin
                    push(crc_run, 1'b1, 1'b0);
                    open    = 1'b0;
                    crc_run = CRC_INIT;
                end
            end
        endfunction

        // Compare one output item with the oldest prediction
        function void check_result(logic [7:0] d, logic fe, logic er);
            result_t exp_r;
            if (due_bytes.size() == 0) begin
                $display("%0t: unexpected output byte %02h end %0b err %0b", $time, d, fe, er);
                failures++;
                return;
            end
            exp_r = due_bytes.pop_front();
            if (d !== exp_r.data) begin
                $display("%0t: out_byte expected %02h got %02h", $time, exp_r.data, d);
                failures++;
            end
            if (fe !== exp_r.frame_end) begin
                $display("%0t: frame_end expected %0b got %0b", $time, exp_r.frame_end, fe);
                failures++;
            end
            if (er !== exp_r.error) begin
                $display("%0t: error expected %0b got %0b", $time, exp_r.error, er);
                failures++;
            end
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       kind = KIND_HEADER;
    logic [7:0] command = 8'h00;
    logic [7:0] length = 8'h00;
    logic [7:0] payload_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       error;

    frame_tracker tracker;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           n_sent = 0;

    command_frame_builder_crc8_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .command      (command),
        .length       (length),
        .payload_byte (payload_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .frame_end    (frame_end),
        .error        (error)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the output at the rate of the current phase
    always @(posedge clk)
    begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Check every output item taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(out_byte, frame_end, error);
    end

    // Present one item, idling first at random, and hold it until taken
    task automatic send_item(logic k, logic [7:0] cmd, logic [7:0] len, logic [7:0] pb);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        command      <= cmd;
        length       <= len;
        payload_byte <= pb;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_item(k, cmd, len, pb);
        n_sent++;
    endtask

    task automatic send_header(logic [7:0] cmd, logic [7:0] len);
        send_item(KIND_HEADER, cmd, len, 8'($urandom));
    endtask

    task automatic send_payload(logic [7:0] pb);
        send_item(KIND_PAYLOAD, 8'($urandom), 8'($urandom), pb);
    endtask

    // Hold off input until every predicted byte has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_version(logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        tracker.set_version(v);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, some noise and broken frames
    task automatic random_frames(int n);
        int target;
        int r;
        int len;
        target = n_sent + n;
        while (n_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_payload(8'($urandom));
            else if (r < 14)
                send_header(8'($urandom), 8'($urandom_range(255, MAX_PAYLOAD + 1)));
            else
            begin
                r = $urandom_range(99);
                if (r < 15)
                    len = 0;
                else if (r < 85)
                    len = $urandom_range(4, 1);
                else if (r < 97)
                    len = $urandom_range(20, 5);
                else if (r < 99)
                    len = $urandom_range(MAX_PAYLOAD - 1, 21);
                else
                    len = MAX_PAYLOAD;
                send_header(8'($urandom), 8'(len));
                for (int i = 0; i < len; i++)
                begin
                    // Drop the rest of the frame now and then; the next header abandons it
                    if ($urandom_range(99) < 2)
                        break;
                    if ($urandom_range(99) < 3)
                        send_header(8'($urandom), 8'($urandom_range(255, MAX_PAYLOAD + 1)));
                    send_payload(8'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, bad lengths, stray payloads, abandoned frames
        send_payload(8'hFF);
        send_header(8'h00, 8'h00);
        send_header(8'hFF, 8'h00);
        send_header(8'h5A, 8'(MAX_PAYLOAD + 1));
        send_header(8'h12, 8'hFF);
        send_header(8'h01, 8'h01);
        send_payload(8'h00);
        send_payload(8'hAA);
        send_header(8'h80, 8'h02);
        send_payload(8'hFF);
        send_header(8'h33, 8'hC8);
        send_payload(8'h55);
        send_header(8'h7F, 8'h03);
        send_payload(8'hA5);
        send_header(8'hC3, 8'h00);
        send_header(8'h3C, 8'h02);
        send_payload(8'h01);
        send_header(8'hE7, 8'h01);
        send_payload(8'h80);
        send_payload(8'h7E);
        drain();

        // Random phases, each after a version change while idle
        write_version(8'hFF);
        idle_pct = 0;  stall_pct = 0;
        random_frames(12);
        drain();

        write_version(8'h00);
        idle_pct = 72; stall_pct = 0;
        random_frames(12);
        drain();

        write_version(8'($urandom));
        idle_pct = 0;  stall_pct = 72;
        random_frames(12);
        drain();

        write_version(8'($urandom));
        idle_pct = 23; stall_pct = 23;
        random_frames(12);
        drain();

        // Run the sequence number through its wrap with empty frames
        write_version(VERSION_RST);
        idle_pct = 23; stall_pct = 23;
        do
            send_header(8'($urandom), 8'h00);
        while (tracker.seq != 8'h00);
        send_header(8'($urandom), 8'h00);
        random_frames(5);

        drain();
        repeat (10) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule
